// ===== hdl/icymd_pkg.sv =====
// Shared types, codes and constants for the stream-title demultiplexer.
// Used by icymd_parser, icymd_result_fifo and icy_metadata_demux.
package icymd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_AUDIO   = 2'd0;
    localparam logic [1:0] KIND_TITLE   = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ABANDON = 2'd3;

    localparam int STRIDE_W   = 24;
    localparam int META_W     = 12;
    localparam int MAX_RES    = 3;   // results one byte can cause
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [3:0] TAG_LAST = 4'd12;  // index of the closing quote of the tag

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [0:0] {
        PH_AUDIO,
        PH_META
    } phase_t;

    typedef enum logic [1:0] {
        SM_SEARCH,
        SM_TITLE,
        SM_DONE
    } search_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
    } res_t;

    // Results of one byte, in order, plus how many are used
    typedef struct packed {
        logic [1:0]             n;
        res_t [MAX_RES-1:0]     r;
    } res_bundle_t;

    // Characters of StreamTitle='
    function automatic logic [7:0] tag_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h53; // S
            4'd1:    c = 8'h74; // t
            4'd2:    c = 8'h72; // r
            4'd3:    c = 8'h65; // e
            4'd4:    c = 8'h61; // a
            4'd5:    c = 8'h6D; // m
            4'd6:    c = 8'h54; // T
            4'd7:    c = 8'h69; // i
            4'd8:    c = 8'h74; // t
            4'd9:    c = 8'h6C; // l
            4'd10:   c = 8'h65; // e
            4'd11:   c = 8'h3D; // =
            4'd12:   c = 8'h27; // '
            default: c = 8'h00; // never matches a nonzero byte
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/icy_metadata_demux.sv =====
// Top level of the stream-title demultiplexer: input register, parser, result queue.
// Depends on icymd_pkg, icymd_parser and icymd_result_fifo.
//
// Usage:
//   Byte channel (byte_valid / byte_stall / in_byte): one raw stream byte per transfer.
//   Result channel (res_valid / res_stall / kind, data_byte, last): one result per
//   transfer; a byte yields zero to three results, the final one flagged by last.
//   stride_we / stride_wdata write the metadata interval; write it only while idle.
//   A write restarts framing in the audio phase and drops any title in progress.
// Timing:
//   A transferred byte waits in the input register until the queue has room, is
//   parsed in that cycle, and its results are offered from the following cycle on.
//   One byte per cycle is sustained while results drain at one per cycle and no
//   byte yields more than one; the four-entry queue and single result port set that figure.
//   The input register advances only when the queue holds at most one entry,
//   so a byte that yields three results never overflows it.
// Reset: stride is zero (every byte passes as audio), queue empty, matcher clear.
// Stall: while res_stall is high the queue fills and byte_stall rises; nothing
//   is lost and the offered result holds steady.
module icy_metadata_demux (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stride_we,
    input  logic [icymd_pkg::STRIDE_W-1:0]  stride_wdata,
    input  logic                            byte_valid,
    output logic                            byte_stall,
    input  logic [7:0]                      in_byte,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [1:0]                      kind,
    output logic [7:0]                      data_byte,
    output logic                            last
);

    logic                   in_vld_reg, in_vld_next;
    logic [7:0]             in_byte_reg;
    logic                   go;
    logic                   room;
    logic                   pop;
    icymd_pkg::res_bundle_t results;
    icymd_pkg::res_t        head;

    // parse the held byte when the queue can take its worst case
    assign go          = in_vld_reg && room;
    assign byte_stall  = in_vld_reg && !room;
    assign in_vld_next = (byte_valid && !byte_stall) || (in_vld_reg && !go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall) begin
            in_byte_reg <= in_byte;
        end
    end

    icymd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .stride_we    (stride_we),
        .stride_wdata (stride_wdata),
        .go           (go),
        .cur_byte     (in_byte_reg),
        .res          (results)
    );

    assign pop = res_valid && !res_stall;

    icymd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (results),
        .pop       (pop),
        .room      (room),
        .not_empty (res_valid),
        .head      (head)
    );

    assign kind      = head.kind;
    assign data_byte = head.data_byte;
    assign last      = head.last;

endmodule

// ===== hdl/icymd_parser.sv =====
// Framing counters, tag matcher and title extraction for one byte per cycle.
// Depends on icymd_pkg.
module icymd_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stride_we,
    input  logic [icymd_pkg::STRIDE_W-1:0]  stride_wdata,
    input  logic                            go,
    input  logic [7:0]                      cur_byte,
    output icymd_pkg::res_bundle_t          res
);

    logic [icymd_pkg::STRIDE_W-1:0] stride_reg, stride_next;
    logic [icymd_pkg::STRIDE_W-1:0] audio_left_reg, audio_left_next;
    logic [icymd_pkg::META_W-1:0]   meta_left_reg, meta_left_next;
    logic [3:0]                     match_pos_reg, match_pos_next;
    icymd_pkg::phase_t              phase_reg, phase_next;
    icymd_pkg::search_t             sm_reg, sm_next;
    logic                           quote_reg, quote_next;

    // matcher step, before end-of-block handling
    icymd_pkg::search_t             sm_after;
    logic [3:0]                     match_after;
    logic                           quote_after;
    logic [icymd_pkg::META_W-1:0]   meta_dec;
    logic                           meta_end;
    logic                           audio_pass;

    assign audio_pass = (stride_reg == '0) || (audio_left_reg != '0);
    assign meta_dec   = (meta_left_reg != '0) ? meta_left_reg - 1'b1 : meta_left_reg;
    assign meta_end   = (meta_dec == '0);

    always_comb
    begin
        sm_after    = sm_reg;
        match_after = match_pos_reg;
        quote_after = quote_reg;
        case (sm_reg)
            icymd_pkg::SM_SEARCH:
            begin
                if (cur_byte == icymd_pkg::CH_NUL) begin
                    sm_after = icymd_pkg::SM_DONE;
                end else if (cur_byte == icymd_pkg::tag_char(match_pos_reg)) begin
                    if (match_pos_reg == icymd_pkg::TAG_LAST) begin
                        sm_after    = icymd_pkg::SM_TITLE;
                        match_after = '0;
                        quote_after = 1'b0;
                    end else begin
                        match_after = match_pos_reg + 4'd1;
                    end
                end else begin
                    match_after = (cur_byte == icymd_pkg::tag_char(4'd0)) ? 4'd1 : 4'd0;
                end
            end
            icymd_pkg::SM_TITLE:
            begin
                if (quote_reg && cur_byte == icymd_pkg::CH_SEMI) begin
                    quote_after = 1'b0;
                    sm_after    = icymd_pkg::SM_DONE;
                end else begin
                    quote_after = 1'b0;
                    if (cur_byte == icymd_pkg::CH_NUL) begin
                        sm_after = icymd_pkg::SM_DONE;
                    end else if (cur_byte == icymd_pkg::CH_QUOTE) begin
                        quote_after = 1'b1;
                    end
                end
            end
            default:
            begin
                sm_after = sm_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        stride_next     = stride_reg;
        audio_left_next = audio_left_reg;
        meta_left_next  = meta_left_reg;
        match_pos_next  = match_pos_reg;
        phase_next      = phase_reg;
        sm_next         = sm_reg;
        quote_next      = quote_reg;
        if (stride_we) begin
            stride_next     = stride_wdata;
            audio_left_next = stride_wdata;
            meta_left_next  = '0;
            phase_next      = icymd_pkg::PH_AUDIO;
            match_pos_next  = '0;
            sm_next         = icymd_pkg::SM_SEARCH;
            quote_next      = 1'b0;
        end else if (go) begin
            if (phase_reg == icymd_pkg::PH_AUDIO) begin
                if (audio_pass) begin
                    if (stride_reg != '0) begin
                        audio_left_next = audio_left_reg - 1'b1;
                    end
                end else if (cur_byte == icymd_pkg::CH_NUL) begin
                    audio_left_next = stride_reg;
                end else begin
                    meta_left_next = {cur_byte, 4'b0000};  // L * 16
                    phase_next     = icymd_pkg::PH_META;
                    match_pos_next = '0;
                    sm_next        = icymd_pkg::SM_SEARCH;
                    quote_next     = 1'b0;
                end
            end else begin
                meta_left_next = meta_dec;
                if (meta_end) begin
                    phase_next      = icymd_pkg::PH_AUDIO;
                    audio_left_next = stride_reg;
                    match_pos_next  = '0;
                    sm_next         = icymd_pkg::SM_SEARCH;
                    quote_next      = 1'b0;
                end else begin
                    match_pos_next = match_after;
                    sm_next        = sm_after;
                    quote_next     = quote_after;
                end
            end
        end
    end

    // results of this byte
    always_comb
    begin
        logic [1:0] n;
        n   = 2'd0;
        res = '0;
        if (go && !stride_we) begin
            if (phase_reg == icymd_pkg::PH_AUDIO) begin
                if (audio_pass) begin
                    res.r[n] = '{icymd_pkg::KIND_AUDIO, cur_byte, 1'b0};
                    n = n + 2'd1;
                end
            end else begin
                if (sm_reg == icymd_pkg::SM_TITLE) begin
                    if (quote_reg && cur_byte == icymd_pkg::CH_SEMI) begin
                        res.r[n] = '{icymd_pkg::KIND_DONE, 8'h00, 1'b0};
                        n = n + 2'd1;
                    end else begin
                        if (quote_reg) begin
                            res.r[n] = '{icymd_pkg::KIND_TITLE, icymd_pkg::CH_QUOTE, 1'b0};
                            n = n + 2'd1;
                        end
                        if (cur_byte == icymd_pkg::CH_NUL) begin
                            res.r[n] = '{icymd_pkg::KIND_ABANDON, 8'h00, 1'b0};
                            n = n + 2'd1;
                        end else if (cur_byte != icymd_pkg::CH_QUOTE) begin
                            res.r[n] = '{icymd_pkg::KIND_TITLE, cur_byte, 1'b0};
                            n = n + 2'd1;
                        end
                    end
                end
                // block ran out while inside a title
                if (meta_end && sm_after == icymd_pkg::SM_TITLE) begin
                    res.r[n] = '{icymd_pkg::KIND_ABANDON, 8'h00, 1'b0};
                    n = n + 2'd1;
                end
            end
        end
        if (n != 2'd0) begin
            res.r[n - 2'd1].last = 1'b1;
        end
        res.n = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stride_reg     <= '0;
            audio_left_reg <= '0;
            meta_left_reg  <= '0;
            match_pos_reg  <= '0;
            phase_reg      <= icymd_pkg::PH_AUDIO;
            sm_reg         <= icymd_pkg::SM_SEARCH;
            quote_reg      <= 1'b0;
        end else begin
            stride_reg     <= stride_next;
            audio_left_reg <= audio_left_next;
            meta_left_reg  <= meta_left_next;
            match_pos_reg  <= match_pos_next;
            phase_reg      <= phase_next;
            sm_reg         <= sm_next;
            quote_reg      <= quote_next;
        end
    end

endmodule

// ===== hdl/icymd_result_fifo.sv =====
// Result queue: takes up to three results a cycle, hands out one a cycle.
// Depends on icymd_pkg.
module icymd_result_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  icymd_pkg::res_bundle_t      push,
    input  logic                        pop,
    output logic                        room,
    output logic                        not_empty,
    output icymd_pkg::res_t             head
);

    icymd_pkg::res_t                mem_reg [icymd_pkg::FIFO_DEPTH];
    logic [icymd_pkg::PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [icymd_pkg::PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [icymd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    // room for a worst-case byte regardless of the reader
    assign room      = (cnt_reg <= icymd_pkg::CNT_W'(icymd_pkg::FIFO_DEPTH - icymd_pkg::MAX_RES));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + icymd_pkg::PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + icymd_pkg::PTR_W'(pop);
        cnt_next    = cnt_reg + icymd_pkg::CNT_W'(push.n) - icymd_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < icymd_pkg::MAX_RES; i++) begin
            if (2'(i) < push.n) begin
                mem_reg[wr_ptr_reg + icymd_pkg::PTR_W'(i)] <= push.r[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("result push without room");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("result pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg == $past(cnt_reg) + icymd_pkg::CNT_W'($past(push.n))
                             - icymd_pkg::CNT_W'($past(pop))))
        else $error("result count out of step with transfers");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= icymd_pkg::CNT_W'(icymd_pkg::FIFO_DEPTH))
        else $error("result count beyond depth");

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for icy_metadata_demux: byte driver, result monitor, inline predictor.
// Depends on icymd_pkg (result kinds, character codes, phase and search enums).
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAG_LEN      = 13;
    localparam logic [8*TAG_LEN-1:0] TAG_STR = "StreamTitle='";
    localparam int FLUSH_CYCLES = 12;      // parse stage plus queue, with margin
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int MAX_PRINTS   = 100;
    localparam int STRIDE_MAX   = (1 << icymd_pkg::STRIDE_W) - 1;

    // ---------------------------------------------------------------- DUT ports
    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           stride_we    = 1'b0;
    logic [icymd_pkg::STRIDE_W-1:0] stride_wdata = '0;
    logic                           byte_valid   = 1'b0;
    logic                           byte_stall;
    logic [7:0]                     in_byte      = 8'h00;
    logic                           res_valid;
    logic                           res_stall    = 1'b0;
    logic [1:0]                     kind;
    logic [7:0]                     data_byte;
    logic                           last;

    icy_metadata_demux i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .stride_we    (stride_we),
        .stride_wdata (stride_wdata),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .in_byte      (in_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .last         (last)
    );

    // ---------------------------------------------------------------- run control
    int   send_idle = 0;      // percent of cycles the byte side idles
    int   recv_idle = 0;      // percent of cycles the result side stalls
    logic recv_hold = 1'b0;   // long hold-off, owned by the hold-off process
    logic hold_go   = 1'b0;
    int   err_count = 0;

    logic [7:0] pending_bytes[$];   // bytes still to be offered, head is on the bus
    logic [7:0] meta_buf[$];        // scratch for one metadata block
    int         gen_count;
    int         gen_stride;

    // ---------------------------------------------------------------- title predictor
    // Own copy of the framing and matcher state; updated on every byte transfer.
    logic [icymd_pkg::STRIDE_W-1:0] pr_stride     = '0;
    logic [icymd_pkg::STRIDE_W-1:0] pr_audio_left = '0;
    icymd_pkg::phase_t              pr_phase      = icymd_pkg::PH_AUDIO;
    logic [icymd_pkg::META_W-1:0]   pr_meta_left  = '0;
    logic [3:0]                     pr_match      = '0;
    icymd_pkg::search_t             pr_search     = icymd_pkg::SM_SEARCH;
    logic                           pr_quote      = 1'b0;

    icymd_pkg::res_t step_res[$];       // results of the byte being predicted
    icymd_pkg::res_t expected_res[$];   // results still owed by the DUT, oldest first

    function automatic logic [7:0] tag_at(logic [3:0] pos);
        return TAG_STR[8*(TAG_LEN-1-int'(pos)) +: 8];
    endfunction

    function automatic void clear_match();
        pr_match  = '0;
        pr_search = icymd_pkg::SM_SEARCH;
        pr_quote  = 1'b0;
    endfunction

    function automatic void set_stride(logic [icymd_pkg::STRIDE_W-1:0] v);
        pr_stride     = v;
        pr_phase      = icymd_pkg::PH_AUDIO;
        pr_audio_left = v;
        pr_meta_left  = '0;
        clear_match();
    endfunction

    function automatic void push_res(logic [1:0] k, logic [7:0] d);
        icymd_pkg::res_t r;
        r.kind      = k;
        r.data_byte = d;
        r.last      = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        step_res.delete();
        if (pr_phase != icymd_pkg::PH_META)
        begin
            if (pr_stride == 0 || pr_audio_left != 0)
            begin
                push_res(icymd_pkg::KIND_AUDIO, b);
                if (pr_stride != 0)
                    pr_audio_left--;
            end
            else if (b == icymd_pkg::CH_NUL)
                pr_audio_left = pr_stride;   // empty metadata block
            else
            begin
                pr_meta_left = {b, 4'b0000};
                pr_phase     = icymd_pkg::PH_META;
                clear_match();
            end
        end
        else
        begin
            if (pr_search == icymd_pkg::SM_SEARCH)
            begin
                if (b == icymd_pkg::CH_NUL)
                    pr_search = icymd_pkg::SM_DONE;
                else if (b == tag_at(pr_match))
                begin
                    if (pr_match == icymd_pkg::TAG_LAST)
                    begin
                        pr_search = icymd_pkg::SM_TITLE;
                        pr_match  = '0;
                        pr_quote  = 1'b0;
                    end
                    else
                        pr_match++;
                end
                else
                    pr_match = (b == tag_at(4'd0)) ? 4'd1 : 4'd0;
            end
            else if (pr_search == icymd_pkg::SM_TITLE)
            begin
                if (pr_quote && b == icymd_pkg::CH_SEMI)
                begin
                    push_res(icymd_pkg::KIND_DONE, 8'h00);
                    pr_quote  = 1'b0;
                    pr_search = icymd_pkg::SM_DONE;
                end
                else
                begin
                    // a held quote that is not followed by ';' is title text
                    if (pr_quote)
                    begin
                        push_res(icymd_pkg::KIND_TITLE, icymd_pkg::CH_QUOTE);
                        pr_quote = 1'b0;
                    end
                    if (b == icymd_pkg::CH_NUL)
                    begin
                        push_res(icymd_pkg::KIND_ABANDON, 8'h00);
                        pr_search = icymd_pkg::SM_DONE;
                    end
                    else if (b == icymd_pkg::CH_QUOTE)
                        pr_quote = 1'b1;
                    else
                        push_res(icymd_pkg::KIND_TITLE, b);
                end
            end

            if (pr_meta_left != 0)
                pr_meta_left--;
            if (pr_meta_left == 0)
            begin
                // block over mid-title: abandon, any held quote is dropped
                if (pr_search == icymd_pkg::SM_TITLE)
                    push_res(icymd_pkg::KIND_ABANDON, 8'h00);
                pr_phase      = icymd_pkg::PH_AUDIO;
                pr_audio_left = pr_stride;
                clear_match();
            end
        end

        if (step_res.size() > 0)
            step_res[step_res.size()-1].last = 1'b1;
        foreach (step_res[i])
            expected_res.push_back(step_res[i]);
    endfunction

    // ---------------------------------------------------------------- stream builder
    function automatic void send(logic [7:0] b);
        pending_bytes.push_back(b);
        gen_count++;
    endfunction

    function automatic void send_str(string s);
        for (int i = 0; i < s.len(); i++)
            send(s[i]);
    endfunction

    function automatic void buf_str(string s);
        for (int i = 0; i < s.len(); i++)
            meta_buf.push_back(s[i]);
    endfunction

    // One metadata block of `need` bytes: optional lead-in, tag, title and one of
    // several endings, padded and then cut to size (a cut often lands mid-title).
    function automatic void build_meta(int need);
        int         v;
        int         n;
        logic [7:0] c;
        meta_buf.delete();
        v = $urandom_range(0, 5);
        case ($urandom_range(0, 2))
            1:       buf_str("StreamUrl='';");
            2:       buf_str("StreamS");
            default: ;
        endcase
        if (v == 5)
            meta_buf.push_back(icymd_pkg::CH_NUL);      // search stops before the tag
        buf_str("StreamTitle='");
        n = $urandom_range(0, 8);
        repeat (n)
        begin
            c = ($urandom_range(0, 5) == 0) ? icymd_pkg::CH_QUOTE
                                            : 8'($urandom_range(8'h20, 8'h7E));
            meta_buf.push_back(c);
        end
        case (v)
            0:       buf_str("';");
            1:       meta_buf.push_back(icymd_pkg::CH_NUL);
            3:
            begin
                buf_str("'");
                meta_buf.push_back(icymd_pkg::CH_NUL);
            end
            4:       buf_str("'';");
            default: ;
        endcase
        while (meta_buf.size() < need)
        begin
            if (v == 2)
                meta_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));   // title runs to the end
            else
                meta_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (v == 2 && $urandom_range(0, 1))
            meta_buf[need-1] = icymd_pkg::CH_QUOTE;    // quote held when the block ends
    endfunction

    function automatic void send_title_block(int blocks);
        send(8'(blocks));
        build_meta(blocks * 16);
        for (int i = 0; i < blocks * 16; i++)
            send(meta_buf[i]);
    endfunction

    // Mostly well-formed frames with random content, some noise blocks and
    // empty blocks; stops once `target` bytes are queued.
    function automatic void send_frames(int target);
        int pick;
        int len;
        while (gen_count < target)
        begin
            if (gen_stride == 0)
                send(8'($urandom_range(0, 255)));
            else
            begin
                for (int i = 0; i < gen_stride; i++)
                    send(8'($urandom_range(0, 255)));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send(icymd_pkg::CH_NUL);
                else if (pick == 1)
                begin
                    len = $urandom_range(1, 2);
                    send(8'(len));
                    repeat (len * 16)
                        send(8'($urandom_range(0, 255)));
                end
                else
                    send_title_block(1);
            end
        end
    endfunction

    // ---------------------------------------------------------------- mismatch report
    task automatic flag_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------- clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- byte driver
    // Head of pending_bytes sits on the bus; it is predicted and popped on the
    // edge that completes its transfer. A stalled byte is held unchanged.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            in_byte    <= 8'h00;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                predict_byte(in_byte);
                void'(pending_bytes.pop_front());
            end
            if (!(byte_valid && byte_stall))
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    byte_valid <= 1'b1;
                    in_byte    <= pending_bytes[0];
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_mon
        icymd_pkg::res_t want;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_res.size() == 0)
                    flag_mismatch($sformatf("unexpected result kind=%0d data=%02h last=%0b",
                                            kind, data_byte, last));
                else
                begin
                    want = expected_res.pop_front();
                    if (kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                    if (data_byte !== want.data_byte)
                        flag_mismatch($sformatf("data_byte %02h, want %02h",
                                                data_byte, want.data_byte));
                    if (last !== want.last)
                        flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
                end
            end
            res_stall <= recv_hold || ($urandom_range(0, 99) < recv_idle);
        end
    end

    // ---------------------------------------------------------------- long hold-off
    // Receiver stays stalled while the sender keeps offering, so the result
    // queue fills and byte_stall has to rise.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    // ---------------------------------------------------------------- watchdog
    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- sequence
    // Everything queued has gone, nothing owed, then a flush wait so that bytes that
    // cause no result clear the parse stage.
    task automatic wait_idle();
        while (!(pending_bytes.size() == 0 && !byte_valid && expected_res.size() == 0))
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_stride(int v);
        @(posedge clk);
        stride_we    <= 1'b1;
        stride_wdata <= icymd_pkg::STRIDE_W'(v);
        @(posedge clk);
        stride_we    <= 1'b0;
        set_stride(icymd_pkg::STRIDE_W'(v));
        gen_stride = v;
    endtask

    task automatic run_phase(int stride, int target, int s_idle, int r_idle, bit pressure);
        send_idle = s_idle;
        recv_idle = r_idle;
        write_stride(stride);
        gen_count = 0;
        send_frames(target);
        if (pressure)
            hold_go <= 1'b1;
        wait_idle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stride zero after reset: plain pass-through, extreme byte values
        send(8'h00);
        send(8'hFF);
        send(8'h55);
        send(8'hAA);
        wait_idle();

        // stride one: empty block, then a title with a held quote that turns
        // into text, cut by the block end (three results on the last byte)
        write_stride(1);
        send(8'h3C);
        send(icymd_pkg::CH_NUL);
        send(8'hC3);
        send(8'h01);
        send_str("StreamTitle='x'y");
        wait_idle();

        // widest stride: everything stays audio
        write_stride(STRIDE_MAX);
        send(8'h0F);
        send(8'hF0);
        wait_idle();

        // length byte 255 (top of meta_left, unsigned length); the title in
        // progress is dropped by the stride write of the next phase
        write_stride(1);
        send(8'h5A);
        send(8'hFF);
        send_str("StreamTitle='ab");
        wait_idle();

        // random phases across the idling mixes
        run_phase(3, 1, 0, 0, 1'b0);
        run_phase(7, 1, 65, 0, 1'b0);
        run_phase(1, 1, 0, 65, 1'b0);
        run_phase(12, 1, 37, 37, 1'b0);
        run_phase(5, 1, 0, 0, 1'b1);
        run_phase(0, 20, 37, 37, 1'b0);

        if (err_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
